[rtl/lfb_pkg.sv]
// Shared types, constants and CRC step function for the link frame builder.
`timescale 1ns / 1ps
package lfb_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] FIXED_CHECK = 16'hC3C3;
    localparam logic [15:0] POLY_RESET  = 16'hA001;
    localparam logic [7:0]  ORPHAN_BYTE = 8'h00;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENDER_ADDR   = 3'd0,
        REG_RECEIVER_ADDR = 3'd1,
        REG_PROTOCOL_BIT  = 3'd2,
        REG_CHECK_MODE    = 3'd3,
        REG_CRC_POLY      = 3'd4
    } lfb_reg_idx_t;

    typedef enum logic {
        OP_BEGIN   = 1'b0,
        OP_PAYLOAD = 1'b1
    } lfb_opcode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic [2:0] fragment_index;
        logic       final_fragment;
        logic [1:0] message_type;
        logic [7:0] sequence_number;
        logic [7:0] payload_length;
    } lfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
        logic       usage_error;
    } lfb_out_t;

    typedef struct packed {
        logic [7:0]  sender_address;
        logic [7:0]  receiver_address;
        logic        protocol_bit;
        logic        check_mode;
        logic [15:0] crc_polynomial;
    } lfb_cfg_t;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ORPHAN = 2'd2
    } lfb_kind_t;

    // one classified request; for a begin the byte field carries the length
    typedef struct packed {
        lfb_kind_t  kind;
        logic       err;
        logic       close;
        logic [7:0] byte_val;
        logic [2:0] fragment_index;
        logic       final_fragment;
        logic [1:0] message_type;
        logic [7:0] sequence_number;
    } lfb_cmd_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_OPEN_FLAG,
        ST_CTRL_HI,
        ST_SEQ,
        ST_SND,
        ST_RCV,
        ST_LEN,
        ST_DATA,
        ST_CHK_HI,
        ST_CHK_LO,
        ST_CLOSE_FLAG,
        ST_ORPHAN
    } lfb_state_t;

    // reflected CRC-16, one byte, shift right
    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/lfb_front.sv]
// Front end: accepts input requests, tracks frame state and classifies them.
`timescale 1ns / 1ps
module lfb_front
    import lfb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lfb_in_t  s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output lfb_cmd_t push_cmd
);

    logic       open_reg, open_next;
    logic [7:0] rem_reg, rem_next;
    logic       accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        push_cmd.err             = 1'b0;
        push_cmd.close           = 1'b0;
        push_cmd.kind            = KIND_DATA;
        push_cmd.byte_val        = s_data.data_byte;
        push_cmd.fragment_index  = s_data.fragment_index;
        push_cmd.final_fragment  = s_data.final_fragment;
        push_cmd.message_type    = s_data.message_type;
        push_cmd.sequence_number = s_data.sequence_number;
        open_next                = open_reg;
        rem_next                 = rem_reg;
        if (s_data.opcode == OP_BEGIN) begin
            push_cmd.kind     = KIND_BEGIN;
            push_cmd.err      = open_reg;
            push_cmd.byte_val = s_data.payload_length;
            push_cmd.close    = (s_data.payload_length == 8'd0);
            open_next         = (s_data.payload_length != 8'd0);
            rem_next          = s_data.payload_length;
        end else if (!open_reg) begin
            push_cmd.kind = KIND_ORPHAN;
            push_cmd.err  = 1'b1;
        end else begin
            push_cmd.close = (rem_reg == 8'd1);
            open_next      = (rem_reg != 8'd1);
            rem_next       = rem_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            rem_reg  <= 8'd0;
        end else if (accept) begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

[rtl/lfb_cmd_fifo.sv]
// Two-entry request queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
module lfb_cmd_fifo
    import lfb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  lfb_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop,
    output lfb_cmd_t pop_cmd
);

    lfb_cmd_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule

[rtl/lfb_back.sv]
// Back end: byte sequencer with escaping, CRC and the output register.
`timescale 1ns / 1ps
module lfb_back
    import lfb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  lfb_cfg_t cfg,
    input  logic     cmd_valid,
    output logic     cmd_pop,
    input  lfb_cmd_t cmd_in,
    output logic     m_valid,
    input  logic     m_ready,
    output lfb_out_t m_data
);

    lfb_state_t  state_reg, state_next;
    lfb_cmd_t    cmd_reg, cmd_next;
    logic        esc_done_reg, esc_done_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    lfb_out_t    m_item_reg, m_item_next;

    logic        out_free, emit, stuffed, crc_body, needs_esc, step_done, last;
    logic [7:0]  cur_byte, ctrl_hi;
    logic [15:0] chk;

    assign out_free = !m_valid_reg || m_ready;
    assign ctrl_hi  = {cmd_reg.fragment_index, cmd_reg.final_fragment, cfg.protocol_bit,
                       cmd_reg.message_type, cfg.check_mode};
    assign chk      = cfg.check_mode ? crc_reg : FIXED_CHECK;

    // datapath and output side of the sequencer
    always_comb begin
        cur_byte = FLAG_BYTE;
        stuffed  = 1'b0;
        crc_body = 1'b0;
        last     = 1'b0;
        case (state_reg)
            ST_OPEN_FLAG:  cur_byte = FLAG_BYTE;
            ST_CTRL_HI:    begin cur_byte = ctrl_hi;                 crc_body = 1'b1; end
            ST_SEQ:        begin cur_byte = cmd_reg.sequence_number; crc_body = 1'b1; end
            ST_SND:        begin cur_byte = cfg.sender_address;      crc_body = 1'b1; end
            ST_RCV:        begin cur_byte = cfg.receiver_address;    crc_body = 1'b1; end
            ST_LEN: begin
                cur_byte = cmd_reg.byte_val;
                crc_body = 1'b1;
                last     = !cmd_reg.close;
            end
            ST_DATA: begin
                cur_byte = cmd_reg.byte_val;
                crc_body = 1'b1;
                last     = !cmd_reg.close;
            end
            ST_CHK_HI:     begin cur_byte = chk[15:8]; stuffed = 1'b1; end
            ST_CHK_LO:     begin cur_byte = chk[7:0];  stuffed = 1'b1; end
            ST_CLOSE_FLAG: begin cur_byte = FLAG_BYTE; last = 1'b1; end
            ST_ORPHAN:     begin cur_byte = ORPHAN_BYTE; last = 1'b1; end
            default:       cur_byte = FLAG_BYTE;
        endcase
        stuffed = stuffed || crc_body;

        needs_esc = stuffed && !esc_done_reg &&
                    (cur_byte == FLAG_BYTE || cur_byte == ESC_BYTE);
        emit      = (state_reg != ST_FETCH) && out_free;
        step_done = emit && !needs_esc;
        cmd_pop   = (state_reg == ST_FETCH) && cmd_valid;

        cmd_next      = cmd_pop ? cmd_in : cmd_reg;
        esc_done_next = esc_done_reg;
        crc_next      = crc_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;

        if (cmd_pop && cmd_in.kind == KIND_BEGIN) begin
            crc_next = CRC_INIT;
        end
        if (emit) begin
            m_valid_next            = 1'b1;
            m_item_next.usage_error = cmd_reg.err;
            if (needs_esc) begin
                m_item_next.out_byte    = ESC_BYTE;
                m_item_next.last_of_run = 1'b0;
                m_item_next.frame_end   = 1'b0;
                esc_done_next           = 1'b1;
            end else begin
                m_item_next.out_byte    = cur_byte;
                m_item_next.last_of_run = last;
                m_item_next.frame_end   = (state_reg == ST_CLOSE_FLAG);
                esc_done_next           = 1'b0;
                if (crc_body) begin
                    crc_next = crc_feed(crc_reg, cur_byte, cfg.crc_polynomial);
                end
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: begin
                if (cmd_pop) begin
                    case (cmd_in.kind)
                        KIND_BEGIN:  state_next = ST_OPEN_FLAG;
                        KIND_DATA:   state_next = ST_DATA;
                        KIND_ORPHAN: state_next = ST_ORPHAN;
                        default:     state_next = ST_FETCH;
                    endcase
                end
            end
            ST_OPEN_FLAG:  if (step_done) state_next = ST_CTRL_HI;
            ST_CTRL_HI:    if (step_done) state_next = ST_SEQ;
            ST_SEQ:        if (step_done) state_next = ST_SND;
            ST_SND:        if (step_done) state_next = ST_RCV;
            ST_RCV:        if (step_done) state_next = ST_LEN;
            ST_LEN, ST_DATA: begin
                if (step_done) state_next = cmd_reg.close ? ST_CHK_HI : ST_FETCH;
            end
            ST_CHK_HI:     if (step_done) state_next = ST_CHK_LO;
            ST_CHK_LO:     if (step_done) state_next = ST_CLOSE_FLAG;
            ST_CLOSE_FLAG: if (step_done) state_next = ST_FETCH;
            ST_ORPHAN:     if (step_done) state_next = ST_FETCH;
            default:       state_next = ST_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FETCH;
            esc_done_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            esc_done_reg <= esc_done_next;
            crc_reg      <= crc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_item_reg;

endmodule

[rtl/link_frame_builder_crc16_stuffing_unit.sv]
// Top level of the byte-stuffed link frame builder with CRC-16 trailer.
// Usage:
//   s_valid/s_ready/s_data take requests: opcode 0 opens a frame (header is
//   sent), opcode 1 carries one payload byte. m_valid/m_ready/m_data give one
//   line byte per transfer, with last_of_run marking the final byte that a
//   request causes and frame_end the closing 0x7E.
//   cfg_we/cfg_index/cfg_wdata write the station registers; write them only
//   while the block is idle.
// Timing:
//   A request goes into the two-entry queue, is fetched by the byte sequencer
//   and its first byte is registered at the output. The sequencer then emits
//   one line byte per cycle while the output register is free: a payload byte
//   (plus trailer if it closes the frame) or a begin's flag and five header
//   bytes (plus trailer at zero length). The front end keeps taking requests
//   while the queue has room; sustained rate is set by sequencer and output.
// Reset: aresetn (synchronous, active low) empties the queue, closes any
//   open frame, restores register defaults and drops m_valid.
// Stall: while m_ready is low the output byte holds, the sequencer waits and
//   the queue fills; s_ready falls once both queue entries are taken.
`timescale 1ns / 1ps
module link_frame_builder_crc16_stuffing_unit
    import lfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lfb_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lfb_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    lfb_cfg_t cfg_reg;
    logic     push_valid, push_ready, cmd_valid, cmd_pop;
    lfb_cmd_t push_cmd, cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sender_address   <= 8'd0;
            cfg_reg.receiver_address <= 8'd0;
            cfg_reg.protocol_bit     <= 1'b0;
            cfg_reg.check_mode       <= 1'b1;
            cfg_reg.crc_polynomial   <= POLY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SENDER_ADDR:   cfg_reg.sender_address   <= cfg_wdata[7:0];
                REG_RECEIVER_ADDR: cfg_reg.receiver_address <= cfg_wdata[7:0];
                REG_PROTOCOL_BIT:  cfg_reg.protocol_bit     <= cfg_wdata[0];
                REG_CHECK_MODE:    cfg_reg.check_mode       <= cfg_wdata[0];
                REG_CRC_POLY:      cfg_reg.crc_polynomial   <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    lfb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    lfb_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_cmd    (cmd)
    );

    lfb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_in    (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.last_of_run)
        else $error("frame end without last_of_run");

    a_end_is_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.out_byte == FLAG_BYTE)
        else $error("frame end byte is not the delimiter");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("request popped from empty queue");
`endif

endmodule

[bench/lfb_line_byte_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the frame builder, predicts its line bytes and compares them.
module lfb_line_byte_checker
    import lfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  lfb_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  lfb_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    outstanding
);

    lfb_cfg_t    station;
    logic [15:0] running_crc;
    logic [7:0]  bytes_left;
    logic        in_frame;
    logic        flag_misuse;
    lfb_out_t    line_bytes_due[$];
    int          errors = 0;

    // bit-serial form of the shift-right CRC update
    function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] b,
                                              input logic [15:0] poly);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ poly;
            end
        end
        return acc;
    endfunction

    task automatic queue_line(input logic [7:0] b, input logic closing);
        lfb_out_t o;
        o.out_byte    = b;
        o.last_of_run = 1'b0;
        o.frame_end   = closing;
        o.usage_error = flag_misuse;
        line_bytes_due.push_back(o);
    endtask

    task automatic queue_escaped(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            queue_line(ESC_BYTE, 1'b0);
        end
        queue_line(b, 1'b0);
    endtask

    task automatic queue_body(input logic [7:0] b);
        running_crc = crc_after(running_crc, b, station.crc_polynomial);
        queue_escaped(b);
    endtask

    task automatic queue_trailer();
        logic [15:0] chk;
        chk = station.check_mode ? running_crc : FIXED_CHECK;
        queue_escaped(chk[15:8]);
        queue_escaped(chk[7:0]);
        queue_line(FLAG_BYTE, 1'b1);
        in_frame    = 1'b0;
        bytes_left  = 8'd0;
        running_crc = CRC_INIT;
    endtask

    task automatic frame_bytes_for(input lfb_in_t req);
        lfb_out_t last_byte;
        flag_misuse = 1'b0;
        if (req.opcode == OP_BEGIN) begin
            // an open frame is dropped silently, the new header carries the flag
            flag_misuse = in_frame;
            running_crc = CRC_INIT;
            queue_line(FLAG_BYTE, 1'b0);
            queue_body({req.fragment_index, req.final_fragment, station.protocol_bit,
                        req.message_type, station.check_mode});
            queue_body(req.sequence_number);
            queue_body(station.sender_address);
            queue_body(station.receiver_address);
            queue_body(req.payload_length);
            in_frame   = 1'b1;
            bytes_left = req.payload_length;
            if (req.payload_length == 8'd0) begin
                queue_trailer();
            end
        end else if (!in_frame) begin
            flag_misuse = 1'b1;
            queue_line(ORPHAN_BYTE, 1'b0);
        end else begin
            queue_body(req.data_byte);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
                queue_trailer();
            end
        end
        last_byte = line_bytes_due.pop_back();
        last_byte.last_of_run = 1'b1;
        line_bytes_due.push_back(last_byte);
    endtask

    always @(posedge aclk) begin
        lfb_out_t want;
        if (!aresetn) begin
            station.sender_address   = 8'd0;
            station.receiver_address = 8'd0;
            station.protocol_bit     = 1'b0;
            station.check_mode       = 1'b1;
            station.crc_polynomial   = POLY_RESET;
            running_crc = CRC_INIT;
            bytes_left  = 8'd0;
            in_frame    = 1'b0;
            line_bytes_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (line_bytes_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: line byte %02h with nothing expected", $realtime,
                                 m_data.out_byte);
                    end
                end else begin
                    want = line_bytes_due.pop_front();
                    if (m_data.out_byte !== want.out_byte ||
                        m_data.last_of_run !== want.last_of_run ||
                        m_data.frame_end !== want.frame_end ||
                        m_data.usage_error !== want.usage_error) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: byte exp %02h/l%0b/e%0b/u%0b got %02h/l%0b/e%0b/u%0b",
                                     $realtime, want.out_byte, want.last_of_run,
                                     want.frame_end, want.usage_error, m_data.out_byte,
                                     m_data.last_of_run, m_data.frame_end,
                                     m_data.usage_error);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                frame_bytes_for(s_data);
            end
            if (cfg_we) begin
                case (lfb_reg_idx_t'(cfg_index))
                    REG_SENDER_ADDR:   station.sender_address   = cfg_wdata[7:0];
                    REG_RECEIVER_ADDR: station.receiver_address = cfg_wdata[7:0];
                    REG_PROTOCOL_BIT:  station.protocol_bit     = cfg_wdata[0];
                    REG_CHECK_MODE:    station.check_mode       = cfg_wdata[0];
                    REG_CRC_POLY:      station.crc_polynomial   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        mismatch_count <= errors;
        outstanding    <= line_bytes_due.size();
    end

endmodule

[bench/link_frame_builder_crc16_stuffing_unit_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the byte-stuffed link frame builder.
module link_frame_builder_crc16_stuffing_unit_test;
    import lfb_pkg::*;

    localparam int REQUEST_TARGET = 430;
    localparam int PHASE_LEN      = 70;
    localparam int IDLE_LIMIT     = 5000;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    lfb_in_t               s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_ready;
    logic                  m_valid;
    lfb_out_t              m_data;
    int                    mismatch_count;
    int                    outstanding;

    int          burst_left    = 0;
    int          requests_sent = 0;
    int          left_in_frame = 0;
    int          idle_cycles   = 0;
    rx_pattern_t rx_pattern    = RX_OPEN;
    int          pattern_left  = 0;

    link_frame_builder_crc16_stuffing_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfb_line_byte_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver: stretches of steady, light, heavy and periodic back-pressure
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            rx_pattern   <= rx_pattern_t'($urandom_range(0, 3));
            pattern_left <= $urandom_range(16, 160);
        end else begin
            pattern_left <= pattern_left - 1;
        end
        case (rx_pattern)
            RX_OPEN:  m_ready <= 1'b1;
            RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
            default:  m_ready <= (pattern_left % 6 == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("link_frame_builder_crc16_stuffing_unit verification failed");
            $finish;
        end
    end

    function automatic lfb_in_t begin_request(input logic [2:0] frag, input logic fin,
                                              input logic [1:0] mtype, input logic [7:0] seq,
                                              input logic [7:0] len);
        logic [31:0] raw;
        lfb_in_t     r;
        raw = $urandom;
        r = raw[30:0];
        r.opcode          = OP_BEGIN;
        r.fragment_index  = frag;
        r.final_fragment  = fin;
        r.message_type    = mtype;
        r.sequence_number = seq;
        r.payload_length  = len;
        return r;
    endfunction

    function automatic lfb_in_t payload_request(input logic [7:0] data);
        logic [31:0] raw;
        lfb_in_t     r;
        raw = $urandom;
        r = raw[30:0];
        r.opcode    = OP_PAYLOAD;
        r.data_byte = data;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) begin
            return 8'd0;
        end else if (r < 14) begin
            return 8'($urandom_range(1, 6));
        end else if (r < 18) begin
            return 8'($urandom_range(7, 24));
        end
        return 8'($urandom_range(25, 64));
    endfunction

    task automatic send_request(input lfb_in_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        requests_sent++;
        if (req.opcode == OP_BEGIN) begin
            left_in_frame = req.payload_length;
        end else if (left_in_frame > 0) begin
            left_in_frame--;
        end
    endtask

    // outstanding lags the edge by one update, so look only after the next edge
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_settings(input logic [7:0] snd, input logic [7:0] rcv,
                                  input logic proto, input logic mode,
                                  input logic [15:0] poly);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SENDER_ADDR;
        cfg_wdata <= {8'h00, snd};
        @(posedge aclk);
        cfg_index <= REG_RECEIVER_ADDR;
        cfg_wdata <= {8'h00, rcv};
        @(posedge aclk);
        cfg_index <= REG_PROTOCOL_BIT;
        cfg_wdata <= {15'd0, proto};
        @(posedge aclk);
        cfg_index <= REG_CHECK_MODE;
        cfg_wdata <= {15'd0, mode};
        @(posedge aclk);
        cfg_index <= REG_CRC_POLY;
        cfg_wdata <= poly;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase;
        int next_phase_at;
        int roll;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults first: stray payload, empty frame, stuffed header and body
        send_request(payload_request(8'hFF));
        send_request(begin_request(3'd7, 1'b1, 2'd3, 8'hFF, 8'd0));
        send_request(begin_request(3'd0, 1'b0, 2'd0, 8'h7E, 8'd3));
        send_request(payload_request(8'h7D));
        send_request(payload_request(8'h7E));
        send_request(payload_request(8'h00));
        // longest frame, cut short by a new begin
        send_request(begin_request(3'd5, 1'b0, 2'd2, 8'h10, 8'd255));
        send_request(payload_request(8'hFF));
        send_request(begin_request(3'd3, 1'b1, 2'd1, 8'h7D, 8'd1));
        send_request(payload_request(8'h55));
        drain();

        // addresses that need stuffing, fixed checksum, zero polynomial
        write_settings(8'h7E, 8'h7D, 1'b1, 1'b0, 16'h0000);
        send_request(begin_request(3'd3, 1'b1, 2'd3, 8'hAA, 8'd1));  // control high = 0x7E
        send_request(payload_request(8'h00));
        send_request(begin_request(3'd2, 1'b1, 2'd0, 8'h00, 8'd2));
        send_request(payload_request(8'h7E));
        drain();
        // check kind and polynomial change while that frame is still open
        write_settings(8'h7E, 8'h7D, 1'b1, 1'b1, 16'hFFFF);
        send_request(payload_request(8'h7D));
        send_request(begin_request(3'd3, 1'b1, 2'd2, 8'h01, 8'd0));  // control high = 0x7D
        send_request(begin_request(3'd1, 1'b0, 2'd3, 8'h01, 8'd0));
        send_request(payload_request(8'h7E));

        phase = 0;
        next_phase_at = requests_sent;
        while (requests_sent < REQUEST_TARGET) begin
            if (requests_sent >= next_phase_at) begin
                drain();
                case (phase)
                    0: write_settings(8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
                    1: write_settings(8'h00, 8'h00, 1'b0, 1'b0, 16'h0000);
                    default: write_settings(pick_byte(), pick_byte(), 1'($urandom),
                                            1'($urandom),
                                            ($urandom_range(0, 1) == 0) ? POLY_RESET
                                                                        : 16'($urandom));
                endcase
                phase++;
                next_phase_at += PHASE_LEN;
            end
            roll = $urandom_range(0, 99);
            if (left_in_frame == 0) begin
                if (roll < 8) begin
                    send_request(payload_request(pick_byte()));
                end else begin
                    send_request(begin_request(3'($urandom), 1'($urandom), 2'($urandom),
                                               pick_byte(), pick_length()));
                end
            end else if (roll < 4) begin
                send_request(begin_request(3'($urandom), 1'($urandom), 2'($urandom),
                                           pick_byte(), pick_length()));
            end else begin
                send_request(payload_request(pick_byte()));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("link_frame_builder_crc16_stuffing_unit verification clean");
        end else begin
            $display("link_frame_builder_crc16_stuffing_unit verification failed");
        end
        $finish;
    end

endmodule
